>>> rtl/box_drop_placement_core_assert.svh
// Assertion helpers for the box drop placement core.
// Each macro checks one implication on the rising edge of i_clk,
// with checking held off while i_rst_n is low.
`ifndef BOX_DROP_PLACEMENT_CORE_ASSERT_SVH
`define BOX_DROP_PLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication.
`define BDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("box drop placement: same-cycle check failed");

// Next-cycle implication.
`define BDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("box drop placement: next-cycle check failed");

`endif

>>> rtl/bdp_pkg.sv
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared types and constants for the box drop placement core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdp_pkg;

    localparam int MAX_BOXES_DEF = 64;

    localparam logic [15:0] X_MAX   = 16'hFFFF;
    localparam logic [13:0] YZ_MAX  = 14'h3FFF;
    localparam logic [35:0] VOL_MAX = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic [9:0]  box_length;
        logic [9:0]  box_width;
        logic [9:0]  box_height;
        logic [13:0] pos_y;
        logic [13:0] pos_z;
    } t_req;

    typedef struct packed {
        logic [15:0] placed_x;
        logic [15:0] bound_x_low;
        logic [15:0] bound_x_high;
        logic [13:0] bound_y_low;
        logic [14:0] bound_y_high;
        logic [13:0] bound_z_low;
        logic [14:0] bound_z_high;
        logic [35:0] total_volume;
        logic        table_full;
    } t_res;

    // Query token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic        valid;
        logic [13:0] pos_y;
        logic [9:0]  box_width;
        logic [13:0] pos_z;
        logic [9:0]  box_height;
        logic [15:0] max_x;
    } t_scan;

    // Store payload broadcast to every cell; the indexed cell captures it.
    typedef struct packed {
        logic [15:0] x;
        logic [9:0]  length;
        logic [13:0] y;
        logic [9:0]  width;
        logic [13:0] z;
        logic [9:0]  height;
    } t_box;

endpackage

>>> rtl/box_drop_placement_core.sv
// From the edge that takes start, the query walks the cell chain one cell per
// cycle, then the multiply state (ST_MUL) and the update state (ST_UPD) follow,
// and o_done is registered high as the update state ends, for the strobe cycle.
// One box is handled at a time: start is not taken while busy; busy drops as o_done rises,
// so the next start may be taken in the strobe cycle. The receiver cannot stall.
// Reset (synchronous, i_rst_n low): empty table, lows at maximum, highs and volume at zero.
// ----------------------------------------------------------------------------
// box_drop_placement_core
// Drops boxes along x onto a table of placed boxes held in a chain of cells,
// and keeps the bounding box and the net volume of the packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "box_drop_placement_core_assert.svh"

module box_drop_placement_core #(
    parameter int MAX_BOXES = bdp_pkg::MAX_BOXES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bdp_pkg::t_req  i_req,
    output logic           o_done,
    output bdp_pkg::t_res  o_res
);

    localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CntW = $clog2(MAX_BOXES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_UPD
    } t_state;

    t_state r_state;

    bdp_pkg::t_req  r_req;
    logic [CntW-1:0] r_count;
    logic [15:0] r_px;
    logic        r_full;
    logic [19:0] r_lw;
    logic [29:0] r_vol;
    logic [15:0] r_low_x;
    logic [15:0] r_high_x;
    logic [13:0] r_low_y;
    logic [14:0] r_high_y;
    logic [13:0] r_low_z;
    logic [14:0] r_high_z;
    logic [35:0] r_vol_sum;

    logic w_accept;
    logic w_store;
    bdp_pkg::t_scan w_head;
    bdp_pkg::t_scan w_chain [MAX_BOXES+1];
    bdp_pkg::t_box  w_wr_box;

    logic [16:0] w_x_end_sum;
    logic [15:0] w_x_end;
    logic [14:0] w_y_end;
    logic [14:0] w_z_end;
    logic [36:0] w_vol_add;
    logic [15:0] n_low_x;
    logic [15:0] n_high_x;
    logic [13:0] n_low_y;
    logic [14:0] n_high_y;
    logic [13:0] n_low_z;
    logic [14:0] n_high_z;
    logic [35:0] n_vol_sum;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_store  = (r_state == ST_UPD) && !r_full;

    // Inject the query straight from the request port.
    always_comb begin
        w_head.valid      = w_accept;
        w_head.pos_y      = i_req.pos_y;
        w_head.box_width  = i_req.box_width;
        w_head.pos_z      = i_req.pos_z;
        w_head.box_height = i_req.box_height;
        w_head.max_x      = 16'd0;
    end

    assign w_chain[0] = w_head;

    assign w_wr_box.x      = r_px;
    assign w_wr_box.length = r_req.box_length;
    assign w_wr_box.y      = r_req.pos_y;
    assign w_wr_box.width  = r_req.box_width;
    assign w_wr_box.z      = r_req.pos_z;
    assign w_wr_box.height = r_req.box_height;

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        bdp_cell #(
            .CellIdx (g),
            .IdxW    (IdxW),
            .CntW    (CntW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_count  (r_count),
            .i_wr_en  (w_store),
            .i_wr_idx (r_count[IdxW-1:0]),
            .i_wr_box (w_wr_box),
            .i_scan   (w_chain[g]),
            .o_scan   (w_chain[g+1])
        );
    end

    // Bound and volume update for the box being stored.
    assign w_x_end_sum = {1'b0, r_px} + {7'd0, r_req.box_length};
    assign w_x_end     = w_x_end_sum[16] ? bdp_pkg::X_MAX : w_x_end_sum[15:0];
    assign w_y_end     = {1'b0, r_req.pos_y} + {5'd0, r_req.box_width};
    assign w_z_end     = {1'b0, r_req.pos_z} + {5'd0, r_req.box_height};
    assign w_vol_add   = {1'b0, r_vol_sum} + {7'd0, r_vol};

    always_comb begin
        n_low_x   = r_low_x;
        n_high_x  = r_high_x;
        n_low_y   = r_low_y;
        n_high_y  = r_high_y;
        n_low_z   = r_low_z;
        n_high_z  = r_high_z;
        n_vol_sum = r_vol_sum;
        if (!r_full) begin
            if (r_px < r_low_x)              n_low_x  = r_px;
            if (w_x_end > r_high_x)          n_high_x = w_x_end;
            if (r_req.pos_y < r_low_y)       n_low_y  = r_req.pos_y;
            if (w_y_end > r_high_y)          n_high_y = w_y_end;
            if (r_req.pos_z < r_low_z)       n_low_z  = r_req.pos_z;
            if (w_z_end > r_high_z)          n_high_z = w_z_end;
            n_vol_sum = w_vol_add[36] ? bdp_pkg::VOL_MAX : w_vol_add[35:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_low_x   <= bdp_pkg::X_MAX;
            r_high_x  <= 16'd0;
            r_low_y   <= bdp_pkg::YZ_MAX;
            r_high_y  <= 15'd0;
            r_low_z   <= bdp_pkg::YZ_MAX;
            r_high_z  <= 15'd0;
            r_vol_sum <= 36'd0;
            o_done    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Hold until the query leaves the last cell.
                    if (w_chain[MAX_BOXES].valid) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_state   <= ST_IDLE;
                    r_low_x   <= n_low_x;
                    r_high_x  <= n_high_x;
                    r_low_y   <= n_low_y;
                    r_high_y  <= n_high_y;
                    r_low_z   <= n_low_z;
                    r_high_z  <= n_high_z;
                    r_vol_sum <= n_vol_sum;
                    if (!r_full) begin
                        r_count <= r_count + CntW'(1);
                    end
                    o_done <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end

        if (w_accept) begin
            r_req <= i_req;
        end
        if ((r_state == ST_SCAN) && w_chain[MAX_BOXES].valid) begin
            r_px   <= w_chain[MAX_BOXES].max_x;
            r_full <= (r_count == CntW'(MAX_BOXES));
            r_lw   <= {10'd0, r_req.box_length} * {10'd0, r_req.box_width};
        end
        if (r_state == ST_MUL) begin
            r_vol <= {10'd0, r_lw} * {20'd0, r_req.box_height};
        end
        if (r_state == ST_UPD) begin
            o_res.placed_x     <= r_px;
            o_res.bound_x_low  <= n_low_x;
            o_res.bound_x_high <= n_high_x;
            o_res.bound_y_low  <= n_low_y;
            o_res.bound_y_high <= n_high_y;
            o_res.bound_z_low  <= n_low_z;
            o_res.bound_z_high <= n_high_z;
            o_res.total_volume <= n_vol_sum;
            o_res.table_full   <= r_full;
        end
    end

    `BDP_ASSERT_IMPL(a_tail_in_scan, w_chain[MAX_BOXES].valid, r_state == ST_SCAN)
    `BDP_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CntW'(MAX_BOXES))
    `BDP_ASSERT_NEXT(a_store_counts, w_store, r_count == $past(r_count) + CntW'(1))
    `BDP_ASSERT_NEXT(a_full_holds, (r_state == ST_UPD) && r_full, $stable(r_count))

endmodule

>>> rtl/bdp_cell.sv
// ----------------------------------------------------------------------------
// bdp_cell
// One slot of the placement table: holds one box and folds its far-x end
// into the passing query token when the y-z rectangles overlap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdp_cell #(
    parameter int CellIdx = 0,
    parameter int IdxW    = 6,
    parameter int CntW    = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CntW-1:0]     i_count,
    input  logic                i_wr_en,
    input  logic [IdxW-1:0]     i_wr_idx,
    input  bdp_pkg::t_box       i_wr_box,
    input  bdp_pkg::t_scan      i_scan,
    output bdp_pkg::t_scan      o_scan
);

    bdp_pkg::t_box  r_box;
    bdp_pkg::t_scan r_scan;

    logic        w_used;
    logic        w_hit;
    logic [16:0] w_end_sum;
    logic [15:0] w_end;
    logic [14:0] w_y_box_end;
    logic [14:0] w_y_req_end;
    logic [14:0] w_z_box_end;
    logic [14:0] w_z_req_end;
    bdp_pkg::t_scan n_scan;

    assign w_used      = i_count > CntW'(CellIdx);
    assign w_y_box_end = {1'b0, r_box.y} + {5'd0, r_box.width};
    assign w_y_req_end = {1'b0, i_scan.pos_y} + {5'd0, i_scan.box_width};
    assign w_z_box_end = {1'b0, r_box.z} + {5'd0, r_box.height};
    assign w_z_req_end = {1'b0, i_scan.pos_z} + {5'd0, i_scan.box_height};

    // Open intervals: touching faces do not count.
    assign w_hit = w_used
        && ({1'b0, r_box.y} < w_y_req_end) && ({1'b0, i_scan.pos_y} < w_y_box_end)
        && ({1'b0, r_box.z} < w_z_req_end) && ({1'b0, i_scan.pos_z} < w_z_box_end);

    assign w_end_sum = {1'b0, r_box.x} + {7'd0, r_box.length};
    assign w_end     = w_end_sum[16] ? bdp_pkg::X_MAX : w_end_sum[15:0];

    always_comb begin
        n_scan = i_scan;
        if (w_hit && (w_end > i_scan.max_x)) begin
            n_scan.max_x = w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.valid <= 1'b0;
        end else begin
            r_scan.valid <= i_scan.valid;
        end
        r_scan.pos_y      <= n_scan.pos_y;
        r_scan.box_width  <= n_scan.box_width;
        r_scan.pos_z      <= n_scan.pos_z;
        r_scan.box_height <= n_scan.box_height;
        r_scan.max_x      <= n_scan.max_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IdxW'(CellIdx))) begin
            r_box <= i_wr_box;
        end
    end

    assign o_scan = r_scan;

endmodule
